// ----- rtl/perm_enum_pkg.sv -----
// ----------------------------------------------------------------------------
// perm_enum_pkg
// Shared widths, action codes and defaults for the permutation enumerator.
// ----------------------------------------------------------------------------
package perm_enum_pkg;

  localparam int MAX_LETTERS_DEF = 8;

  localparam int ACTION_W   = 2;
  localparam int LETTER_W   = 8;
  localparam int POSITION_W = 3;
  localparam int LENGTH_W   = 4;
  localparam int WORD_W     = 64;

  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_BEGIN = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_NEXT  = 2'd2;

endpackage

// ----- rtl/perm_enum_if.sv -----
// ----------------------------------------------------------------------------
// perm_enum_if
// Valid/ready channels of the permutation enumerator: command in, word out.
// ----------------------------------------------------------------------------
interface perm_enum_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [perm_enum_pkg::ACTION_W-1:0]    action;
  logic [perm_enum_pkg::LETTER_W-1:0]    letter;
  logic [perm_enum_pkg::POSITION_W-1:0]  position;
  logic [perm_enum_pkg::LENGTH_W-1:0]    length;

  modport source (output valid, action, letter, position, length, input ready);
  modport sink   (input valid, action, letter, position, length, output ready);
endinterface

interface perm_enum_out_if;
  logic                               valid;
  logic                               ready;
  logic [perm_enum_pkg::WORD_W-1:0]   word;
  logic                               valid_res;
  logic                               last;

  modport source (output valid, word, valid_res, last, input ready);
  modport sink   (input valid, word, valid_res, last, output ready);
endinterface

// ----- rtl/permutation_enumerator.sv -----
// ----------------------------------------------------------------------------
// permutation_enumerator
// Letter store plus a per-level counter stack stepping through permutations.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries commands: load puts a letter byte into a slot, begin sets
//   the word length (saturated to MAX_LETTERS) and restarts the sequence,
//   next asks for one permutation. Only next gives a result on out_ch.
//   A next item steps from idle through the scan state once per level
//   visited and the rotation state once per letter swap of each level
//   rotation, then the done state. The single swap unit, stepped by the
//   sequencer, does these swaps. in_ch.ready is low while a next item is
//   being worked on.
//   The result word packs letter k into bits 8k+7..8k, zero past the length;
//   last flags the final permutation, valid_res=0 with a zero word means the
//   sequence is exhausted or was never begun.
//   out_ch is a registered output; a stalled receiver holds the finished
//   result and the block waits before posting the next one.
//   After reset all letters are zero, the length is zero and the sequence is
//   exhausted.
// ----------------------------------------------------------------------------
module permutation_enumerator #(
  parameter int MAX_LETTERS = perm_enum_pkg::MAX_LETTERS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  perm_enum_in_if.sink           in_ch,
  perm_enum_out_if.source        out_ch
);

  localparam int IDX_W = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
  localparam int LEN_W = $clog2(MAX_LETTERS + 1);
  localparam int SUM_W = LEN_W + 1;
  localparam int LTR_W = perm_enum_pkg::LETTER_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_ROT  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [LTR_W-1:0]               letters_r [MAX_LETTERS];
  logic [LTR_W-1:0]               letters_nxt [MAX_LETTERS];
  logic [IDX_W-1:0]               cnt_r [MAX_LETTERS];
  logic [IDX_W-1:0]               cnt_nxt [MAX_LETTERS];
  logic [LEN_W-1:0]               len_r, len_nxt;
  logic                           started_r, started_nxt;
  logic                           exhausted_r, exhausted_nxt;
  logic [IDX_W-1:0]               lvl_r, lvl_nxt;
  logic [IDX_W-1:0]               rot_pos_r, rot_pos_nxt;
  logic [perm_enum_pkg::WORD_W-1:0] word_r, word_nxt;
  logic                           res_valid_r, res_valid_nxt;
  logic                           res_last_r, res_last_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [perm_enum_pkg::WORD_W-1:0] out_word_r, out_word_nxt;
  logic                           out_vres_r, out_vres_nxt;
  logic                           out_last_r, out_last_nxt;

  // shared swap unit
  logic                           sw_en;
  logic [IDX_W-1:0]               sw_a, sw_b;

  logic                           in_xfer;
  logic [SUM_W-1:0]               scan_target;
  logic [SUM_W-1:0]               rot_end;
  logic [perm_enum_pkg::WORD_W-1:0] packed_word;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.word      = out_word_r;
  assign out_ch.valid_res = out_vres_r;
  assign out_ch.last      = out_last_r;

  // front letter of the level goes against slot base + c + 1
  assign scan_target = SUM_W'(lvl_r) + SUM_W'(cnt_r[lvl_r]) + SUM_W'(1);
  assign rot_end     = SUM_W'(rot_pos_r) + SUM_W'(2);

  always_comb begin
    packed_word = '0;
    for (int k = 0; k < MAX_LETTERS; k++) begin
      if (LEN_W'(k) < len_r) begin
        packed_word[8*k +: 8] = letters_r[k];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    started_nxt   = started_r;
    exhausted_nxt = exhausted_r;
    lvl_nxt       = lvl_r;
    rot_pos_nxt   = rot_pos_r;
    word_nxt      = word_r;
    res_valid_nxt = res_valid_r;
    res_last_nxt  = res_last_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_vres_nxt  = out_vres_r;
    out_last_nxt  = out_last_r;
    sw_en         = 1'b0;
    sw_a          = lvl_r;
    sw_b          = lvl_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_ch.action)
            perm_enum_pkg::ACT_BEGIN: begin
              if (in_ch.length > perm_enum_pkg::LENGTH_W'(MAX_LETTERS)) begin
                len_nxt = LEN_W'(MAX_LETTERS);
              end else begin
                len_nxt = LEN_W'(in_ch.length);
              end
              for (int e = 0; e < MAX_LETTERS; e++) begin
                cnt_nxt[e] = '0;
              end
              started_nxt   = 1'b1;
              exhausted_nxt = (in_ch.length == '0);
            end
            perm_enum_pkg::ACT_NEXT: begin
              if (!started_r || exhausted_r) begin
                word_nxt      = '0;
                res_valid_nxt = 1'b0;
                res_last_nxt  = 1'b0;
                state_nxt     = S_DONE;
              end else begin
                word_nxt      = packed_word;
                res_valid_nxt = 1'b1;
                if (len_r < LEN_W'(2)) begin
                  res_last_nxt = 1'b1;
                  state_nxt    = S_DONE;
                end else begin
                  res_last_nxt = 1'b0;
                  lvl_nxt      = IDX_W'(len_r - LEN_W'(2));
                  state_nxt    = S_SCAN;
                end
              end
            end
            default: begin
              // loads are handled in the letter store, other codes do nothing
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_target < SUM_W'(len_r)) begin
          sw_en          = 1'b1;
          sw_a           = lvl_r;
          sw_b           = scan_target[IDX_W-1:0];
          cnt_nxt[lvl_r] = cnt_r[lvl_r] + IDX_W'(1);
          for (int e = 0; e < MAX_LETTERS; e++) begin
            if (IDX_W'(e) > lvl_r) begin
              cnt_nxt[e] = '0;
            end
          end
          state_nxt = S_DONE;
        end else begin
          // level finished: rotate its segment back into place
          cnt_nxt[lvl_r] = '0;
          rot_pos_nxt    = lvl_r;
          state_nxt      = S_ROT;
        end
      end

      S_ROT: begin
        sw_en = 1'b1;
        sw_a  = rot_pos_r;
        sw_b  = rot_pos_r + IDX_W'(1);
        if (rot_end == SUM_W'(len_r)) begin
          if (lvl_r == '0) begin
            res_last_nxt = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            lvl_nxt   = lvl_r - IDX_W'(1);
            state_nxt = S_SCAN;
          end
        end else begin
          rot_pos_nxt = rot_pos_r + IDX_W'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = word_r;
          out_vres_nxt  = res_valid_r;
          out_last_nxt  = res_last_r;
          if (res_valid_r && res_last_r) begin
            exhausted_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // letter store: load writes one slot, the swap unit exchanges two
  always_comb begin
    letters_nxt = letters_r;
    if (in_xfer && in_ch.action == perm_enum_pkg::ACT_LOAD &&
        {1'b0, in_ch.position} < (perm_enum_pkg::POSITION_W + 1)'(MAX_LETTERS)) begin
      letters_nxt[in_ch.position[IDX_W-1:0]] = in_ch.letter;
    end
    if (sw_en) begin
      letters_nxt[sw_a] = letters_r[sw_b];
      letters_nxt[sw_b] = letters_r[sw_a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      started_r   <= 1'b0;
      exhausted_r <= 1'b1;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_LETTERS; k++) begin
        letters_r[k] <= '0;
        cnt_r[k]     <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      started_r   <= started_nxt;
      exhausted_r <= exhausted_nxt;
      out_valid_r <= out_valid_nxt;
      letters_r   <= letters_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r       <= lvl_nxt;
    rot_pos_r   <= rot_pos_nxt;
    word_r      <= word_nxt;
    res_valid_r <= res_valid_nxt;
    res_last_r  <= res_last_nxt;
    out_word_r  <= out_word_nxt;
    out_vres_r  <= out_vres_nxt;
    out_last_r  <= out_last_nxt;
  end

`ifndef SYNTHESIS
  // an exhausted or unbegun request carries an empty word
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.valid_res |-> out_ch.word == '0 && !out_ch.last)
    else $error("empty result carries data");

  // the scanned level always leaves at least two letters in its segment
  a_scan_level: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> SUM_W'(lvl_r) + SUM_W'(2) <= SUM_W'(len_r))
    else $error("scan level outside word");

  // rotation stays inside the segment of the current level
  a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROT |-> rot_pos_r >= lvl_r && rot_end <= SUM_W'(len_r))
    else $error("rotation outside segment");
`endif

endmodule
